[design/tsc_pkg.sv]
package tsc_pkg;

	localparam int unsigned MEM_DEPTH_DEF = 4096;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned OPC_W         = 8;
	localparam int unsigned SHAMT_W       = $clog2(WORD_W);
	localparam int unsigned CODE_SIZE_W   = 13;
	localparam int unsigned LOAD_ADDR_W   = 12;
	localparam int unsigned STATUS_W      = 3;

	// s_tdata: load_addr, load_data, zero pad
	localparam int unsigned IN_USED_W = LOAD_ADDR_W + WORD_W;
	localparam int unsigned IN_W      = ((IN_USED_W + 7) / 8) * 8;
	// m_tdata: status, stopped, reg_a_out, reg_b_out, stack_ptr_out, prog_ctr_out,
	// executed_count, zero pad
	localparam int unsigned OUT_USED_W = STATUS_W + 1 + 5 * WORD_W;
	localparam int unsigned OUT_W      = ((OUT_USED_W + 7) / 8) * 8;

	typedef enum logic [OPC_W-1:0] {
		OP_LDC  = 8'd0,
		OP_ADC  = 8'd1,
		OP_LDL  = 8'd2,
		OP_STL  = 8'd3,
		OP_LDNL = 8'd4,
		OP_STNL = 8'd5,
		OP_ADD  = 8'd6,
		OP_SUB  = 8'd7,
		OP_SHL  = 8'd8,
		OP_SHR  = 8'd9,
		OP_ADJ  = 8'd10,
		OP_A2SP = 8'd11,
		OP_SP2A = 8'd12,
		OP_CALL = 8'd13,
		OP_RET  = 8'd14,
		OP_BRZ  = 8'd15,
		OP_BRLZ = 8'd16,
		OP_BR   = 8'd17,
		OP_HALT = 8'd18
	} opc_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_HALT    = 3'd1,
		ST_PC      = 3'd2,
		ST_MEM     = 3'd3,
		ST_OPC     = 3'd4,
		ST_STOPPED = 3'd5
	} status_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] sp;
		logic [WORD_W-1:0] pc;
		logic [WORD_W-1:0] cnt;
		logic              run;
	} arch_t;

	localparam arch_t ARCH_RST = '{a: '0, b: '0, sp: '0, pc: '0, cnt: '0, run: 1'b1};

	typedef struct packed {
		arch_t             nxt;
		status_t           status;
		logic              rd;
		logic              wr;
		logic [WORD_W-1:0] ea;
		logic [WORD_W-1:0] wdata;
	} exec_t;

endpackage

[design/tsc_mem.sv]
module tsc_mem #(
	parameter int unsigned DEPTH = tsc_pkg::MEM_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [tsc_pkg::WORD_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [tsc_pkg::WORD_W-1:0] rd_data
);
	import tsc_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/tsc_exec.sv]
module tsc_exec #(
	parameter int unsigned MEM_DEPTH = tsc_pkg::MEM_DEPTH_DEF
) (
	input  tsc_pkg::arch_t                   cur,
	input  logic [tsc_pkg::WORD_W-1:0]       inst,
	input  logic [tsc_pkg::CODE_SIZE_W-1:0]  code_size,
	output tsc_pkg::exec_t                   ex
);
	import tsc_pkg::*;

	logic [WORD_W-1:0] opr;
	logic [WORD_W-1:0] pc1;
	logic [WORD_W-1:0] base;
	logic [WORD_W-1:0] shl_v;
	logic [WORD_W-1:0] shr_v;
	logic [WORD_W:0]   ea;
	logic              ea_ok;
	logic              pc_bad;
	logic              big_shift;
	opc_t              opc;

	assign opc       = opc_t'(inst[OPC_W-1:0]);
	assign opr       = WORD_W'($signed(inst) >>> OPC_W);
	assign pc1       = cur.pc + WORD_W'(1);
	assign pc_bad    = (cur.pc >= WORD_W'(code_size)) || (cur.pc >= WORD_W'(MEM_DEPTH));
	assign base      = (opc == OP_LDL || opc == OP_STL) ? cur.sp : cur.a;
	// exact sum, no wrap
	assign ea        = {base[WORD_W-1], base} + {opr[WORD_W-1], opr};
	assign ea_ok     = !ea[WORD_W] && (ea[WORD_W-1:0] < WORD_W'(MEM_DEPTH));
	assign big_shift = |cur.a[WORD_W-1:SHAMT_W];
	assign shl_v     = big_shift ? '0 : (cur.b << cur.a[SHAMT_W-1:0]);
	assign shr_v     = big_shift ? {WORD_W{cur.b[WORD_W-1]}}
	                             : WORD_W'($signed(cur.b) >>> cur.a[SHAMT_W-1:0]);

	always_comb begin
		ex        = '0;
		ex.nxt    = cur;
		ex.status = ST_OK;
		ex.ea     = ea[WORD_W-1:0];
		ex.wdata  = cur.a;
		if (!cur.run) begin
			ex.status = ST_STOPPED;
		end else if (pc_bad) begin
			ex.nxt.run = 1'b0;
			ex.status  = ST_PC;
		end else begin
			ex.nxt.pc  = pc1;
			ex.nxt.cnt = cur.cnt + WORD_W'(1);
			case (opc)
				OP_LDC: begin
					ex.nxt.b = cur.a;
					ex.nxt.a = opr;
				end
				OP_ADC: ex.nxt.a = cur.a + opr;
				OP_LDL: begin
					ex.nxt.b = cur.a;
					ex.rd    = ea_ok;
				end
				OP_STL: begin
					ex.wr = ea_ok;
					if (ea_ok) begin
						ex.nxt.a = cur.b;
					end
				end
				OP_LDNL: ex.rd = ea_ok;
				OP_STNL: begin
					ex.wr    = ea_ok;
					ex.wdata = cur.b;
				end
				OP_ADD: ex.nxt.a = cur.a + cur.b;
				OP_SUB: ex.nxt.a = cur.b - cur.a;
				OP_SHL: ex.nxt.a = shl_v;
				OP_SHR: ex.nxt.a = shr_v;
				OP_ADJ: ex.nxt.sp = cur.sp + opr;
				OP_A2SP: begin
					ex.nxt.sp = cur.a;
					ex.nxt.a  = cur.b;
				end
				OP_SP2A: begin
					ex.nxt.b = cur.a;
					ex.nxt.a = cur.sp;
				end
				OP_CALL: begin
					ex.nxt.b  = cur.a;
					ex.nxt.a  = pc1;
					ex.nxt.pc = pc1 + opr;
				end
				OP_RET: begin
					ex.nxt.pc = cur.a;
					ex.nxt.a  = cur.b;
				end
				OP_BRZ: begin
					if (cur.a == '0) begin
						ex.nxt.pc = pc1 + opr;
					end
				end
				OP_BRLZ: begin
					if (cur.a[WORD_W-1]) begin
						ex.nxt.pc = pc1 + opr;
					end
				end
				OP_BR: ex.nxt.pc = pc1 + opr;
				OP_HALT: begin
					ex.nxt.run = 1'b0;
					ex.status  = ST_HALT;
				end
				default: begin
					ex.nxt.run = 1'b0;
					ex.status  = ST_OPC;
				end
			endcase
			// memory fault: drop the count, keep the PC bump
			if ((opc == OP_LDL || opc == OP_STL || opc == OP_LDNL || opc == OP_STNL)
			    && !ea_ok) begin
				ex.nxt.cnt = cur.cnt;
				ex.nxt.run = 1'b0;
				ex.status  = ST_MEM;
			end
		end
	end

endmodule

[design/two_register_stack_cpu_step.sv]
// Two-register stack processor, one instruction per step beat.
// Input stream s_*: s_tuser selects the beat kind (0 writes one memory word at
// load_addr, 1 executes the instruction at PC). Output stream m_*: one result
// beat per input beat with the status code and the registers after the item.
// Configuration channel cfg_*: writes code_size; always ready.
// Timing: the instruction fetch is issued in the accept cycle, so a load beat
// or a non-memory instruction finishes in S_LOAD or S_EXEC, entered on accept,
// and the next beat is taken in that same cycle: one item per cycle while the
// receiver keeps up. ldl and ldnl pass through S_MEMRD for the data read. stl
// and stnl finish in S_EXEC, but the next beat waits as the single memory write
// port is busy. The result shows on m_tvalid the cycle after an item finishes;
// the block takes a new beat while that result waits. If the receiver stalls,
// the item after it holds in its last stage and s_tready drops.
// Reset: registers A, B, SP, PC and the count clear and the machine runs; the
// memory is then cleared one word a cycle, with s_tready low. Configuration
// writes are taken during that pass.
module two_register_stack_cpu_step #(
	parameter int unsigned MEM_DEPTH = tsc_pkg::MEM_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [tsc_pkg::IN_W-1:0]         s_tdata,  // load_addr, load_data, pad
	input  logic                             s_tuser,  // req_type
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status, stopped, reg_a_out, reg_b_out, stack_ptr_out, prog_ctr_out,
	// executed_count, pad
	output logic [tsc_pkg::OUT_W-1:0]        m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsc_pkg::CODE_SIZE_W-1:0]  cfg_data
);
	import tsc_pkg::*;

	localparam int unsigned AW = $clog2(MEM_DEPTH);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_EXEC  = 5'b00100,
		S_LOAD  = 5'b01000,
		S_MEMRD = 5'b10000
	} state_t;

	state_t                 state_q, state_nx, after_fin;
	logic [AW-1:0]          clr_q;
	logic [CODE_SIZE_W-1:0] code_size_q;
	arch_t                  arch_q, pend_q, arch_nx;
	exec_t                  ex;
	status_t                status_nx;
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	logic                   out_free, fin, acc, is_step;
	logic [LOAD_ADDR_W-1:0] ld_addr;
	logic [WORD_W-1:0]      ld_data;
	logic                   ld_ok;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_wa, mem_ra;
	logic [WORD_W-1:0]      mem_wd, mem_rd;

	assign ld_addr  = s_tdata[LOAD_ADDR_W-1:0];
	assign ld_data  = s_tdata[IN_USED_W-1:LOAD_ADDR_W];
	assign ld_ok    = WORD_W'(ld_addr) < WORD_W'(MEM_DEPTH);
	assign is_step  = (s_tuser == REQ_STEP);
	assign out_free = !m_tvalid_q || m_tready;

	tsc_exec #(.MEM_DEPTH(MEM_DEPTH)) u_exec (
		.cur       (arch_q),
		.inst      (mem_rd),
		.code_size (code_size_q),
		.ex        (ex)
	);

	always_comb begin
		fin       = 1'b0;
		arch_nx   = arch_q;
		status_nx = ST_OK;
		case (state_q)
			S_EXEC: begin
				fin       = out_free && !ex.rd;
				arch_nx   = ex.nxt;
				status_nx = ex.status;
			end
			S_MEMRD: begin
				fin       = out_free;
				arch_nx   = pend_q;
				arch_nx.a = mem_rd;
			end
			S_LOAD: fin = out_free;
			default: fin = 1'b0;
		endcase
	end

	// hold off a new beat while a store owns the write port
	assign s_tready = (state_q == S_IDLE) || (fin && !(state_q == S_EXEC && ex.wr));
	assign acc      = s_tvalid && s_tready;
	assign after_fin = acc ? (is_step ? S_EXEC : S_LOAD) : S_IDLE;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(MEM_DEPTH - 1)) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: state_nx = after_fin;
			S_EXEC: begin
				if (ex.rd) begin
					state_nx = S_MEMRD;
				end else if (fin) begin
					state_nx = after_fin;
				end
			end
			S_LOAD, S_MEMRD: begin
				if (fin) begin
					state_nx = after_fin;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// memory port control; fetch forwards the PC that commits this cycle
	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(ld_addr);
		mem_wd = ld_data;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == S_EXEC && fin && ex.wr) begin
			mem_we = 1'b1;
			mem_wa = AW'(ex.ea);
			mem_wd = ex.wdata;
		end else if (acc && !is_step) begin
			mem_we = ld_ok;
		end
		if (state_q == S_EXEC && ex.rd) begin
			mem_re = 1'b1;
			mem_ra = AW'(ex.ea);
		end else begin
			mem_re = acc && is_step;
			mem_ra = AW'(arch_nx.pc);
		end
	end

	tsc_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_en   (mem_re),
		.rd_addr (mem_ra),
		.rd_data (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			code_size_q <= '0;
			arch_q      <= ARCH_RST;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_valid) begin
				code_size_q <= cfg_data;
			end
			if (fin) begin
				arch_q <= arch_nx;
			end
			if (fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && ex.rd) begin
			pend_q <= ex.nxt;
		end
		if (fin) begin
			m_tdata_q <= OUT_W'({arch_nx.cnt, arch_nx.pc, arch_nx.sp, arch_nx.b, arch_nx.a,
			                     !arch_nx.run, status_nx});
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

endmodule
